/* hw/rtl/cbf_pkg.sv */
// Package for the chaptered byte FIFO: item kinds, status codes, queue entry type.
// Depends on nothing; used by every module of the block.
package cbf_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE = 3'd0,
    KIND_END   = 3'd1,
    KIND_READ  = 3'd2,
    KIND_DROP  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Decoded item handed from front to back.
  typedef struct packed {
    logic       is_write;
    logic       is_end;
    logic       is_read;
    logic       is_drop;
    logic       is_clear;
    logic [7:0] wr_byte;
    logic [7:0] drop_count;
  } cmd_t;

endpackage

/* hw/rtl/cbf_front.sv */
// Front end: accepts items, decodes kind, holds a two-entry command queue.
// Depends on cbf_pkg.
module cbf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [2:0]      in_kind,
  input  logic [7:0]      in_wr_byte,
  input  logic [7:0]      in_drop_count,
  output logic            cmd_valid,
  output cbf_pkg::cmd_t   cmd,
  input  logic            cmd_take
);

  cbf_pkg::cmd_t q_r [2];
  logic          rd_r, wr_r;
  logic [1:0]    cnt_r;
  cbf_pkg::cmd_t dec;
  logic          acc;

  always_comb begin
    dec = '0;
    dec.wr_byte    = in_wr_byte;
    dec.drop_count = in_drop_count;
    dec.is_write   = (in_kind == 3'(cbf_pkg::KIND_WRITE));
    dec.is_end     = (in_kind == 3'(cbf_pkg::KIND_END));
    dec.is_read    = (in_kind == 3'(cbf_pkg::KIND_READ));
    dec.is_drop    = (in_kind == 3'(cbf_pkg::KIND_DROP));
    dec.is_clear   = (in_kind == 3'(cbf_pkg::KIND_CLEAR));
  end

  assign in_full   = (cnt_r == 2'd2);
  assign acc       = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (acc) q_r[wr_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (acc) wr_r <= ~wr_r;
      if (cmd_take && cmd_valid) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(acc) - 2'(cmd_take && cmd_valid);
    end
  end

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid) else $error("take without command");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !cmd_take) |=> in_full) else $error("full dropped");

endmodule

/* hw/rtl/cbf_back.sv */
// Back end: byte and length stores, pointers, head/tail bookkeeping, result register.
// Depends on cbf_pkg.
module cbf_back #(
  parameter int DATA_DEPTH = 1024,
  parameter int REC_DEPTH  = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  cbf_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [1:0]    out_status,
  output logic [7:0]    out_rd_byte,
  output logic          out_chapter_end,
  output logic [10:0]   out_head_len,
  output logic [6:0]    out_chapter_count,
  output logic [10:0]   out_data_free,
  output logic [6:0]    out_record_free
);

  localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int RAW = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
  localparam int DFW = $clog2(DATA_DEPTH + 1);
  localparam int RFW = $clog2(REC_DEPTH + 1);
  localparam int LW  = DFW;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_LOAD, S_WALK, S_FIN, S_OUT
  } state_t;

  logic [7:0]    bmem [DATA_DEPTH];
  logic [LW-1:0] lmem [REC_DEPTH];

  state_t        st_r;
  cbf_pkg::cmd_t c_r;
  logic [DAW-1:0] brd_r, bwr_r;
  logic [DFW-1:0] bfill_r;
  logic [RAW-1:0] lrd_r, lwr_r;
  logic [RFW-1:0] lfill_r;
  logic [LW-1:0]  head_r, tail_r;
  logic           idle_r;
  logic [7:0]     bq_r;
  logic [LW-1:0]  lq_r;
  logic [LW+8:0]  total_r;
  logic [7:0]     left_r;
  logic           ldhead_r;    // pending record length add in S_FIN, set by S_WALK
  logic [1:0]     stat_r;
  logic           cend_r, ok_r;
  logic [7:0]     rbyte_r;     // byte popped by the current read
  logic           full_r;

  logic [RFW:0]   count;
  assign count = {1'b0, lfill_r} + (RFW+1)'(head_r != '0);

  assign cmd_take  = (st_r == S_IDLE) && cmd_valid;
  assign out_empty = !full_r;

  always_ff @(posedge clk) begin
    bq_r <= bmem[brd_r];
    lq_r <= lmem[lrd_r];
    if (st_r == S_EXEC && c_r.is_write && lfill_r < RFW'(REC_DEPTH)
        && bfill_r < DFW'(DATA_DEPTH))
      bmem[bwr_r] <= c_r.wr_byte;
    if (st_r == S_EXEC && c_r.is_end && tail_r != '0 && lfill_r < RFW'(REC_DEPTH))
      lmem[lwr_r] <= tail_r;
  end

  function automatic logic [DAW-1:0] binc(input logic [DAW-1:0] p);
    return (p == DAW'(DATA_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction
  function automatic logic [RAW-1:0] linc(input logic [RAW-1:0] p);
    return (p == RAW'(REC_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [LW+8:0] tclip;
  logic [DAW+LW+9:0] psum;
  assign tclip = (total_r > (LW+9)'(bfill_r)) ? (LW+9)'(bfill_r) : total_r;
  assign psum  = (DAW+LW+10)'(brd_r) + (DAW+LW+10)'(tclip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; full_r <= 1'b0;
      brd_r <= '0; bwr_r <= '0; bfill_r <= '0;
      lrd_r <= '0; lwr_r <= '0; lfill_r <= '0;
      head_r <= '0; tail_r <= '0; idle_r <= 1'b1;
      ldhead_r <= 1'b0;
    end else begin
      if (out_pop && full_r && st_r != S_OUT) full_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            c_r <= cmd; st_r <= S_EXEC;
            stat_r <= cbf_pkg::ST_OK; cend_r <= 1'b0; ok_r <= 1'b0;
          end
        end
        S_EXEC: begin
          ldhead_r <= 1'b0;
          priority if (c_r.is_write) begin
            st_r <= S_OUT;
            if (lfill_r >= RFW'(REC_DEPTH) || bfill_r >= DFW'(DATA_DEPTH))
              stat_r <= cbf_pkg::ST_FULL;
            else begin
              bwr_r <= binc(bwr_r); bfill_r <= bfill_r + 1'b1;
              tail_r <= tail_r + 1'b1;
            end
          end else if (c_r.is_end) begin
            st_r <= S_OUT;
            if (tail_r == '0) stat_r <= cbf_pkg::ST_EMPTY;
            else if (lfill_r >= RFW'(REC_DEPTH)) stat_r <= cbf_pkg::ST_FULL;
            else begin
              lwr_r <= linc(lwr_r);
              tail_r <= '0;
              if (idle_r) begin
                // record just written becomes head; its value is tail_r
                head_r <= tail_r; idle_r <= 1'b0;
                lrd_r <= linc(lrd_r);
              end else begin
                lfill_r <= lfill_r + 1'b1;
              end
            end
          end else if (c_r.is_read) begin
            if (head_r == '0 || bfill_r == '0) begin
              stat_r <= cbf_pkg::ST_EMPTY;
              st_r <= S_OUT;
            end else begin
              ok_r <= 1'b1;
              rbyte_r <= bq_r;
              brd_r <= binc(brd_r); bfill_r <= bfill_r - 1'b1;
              head_r <= head_r - 1'b1;
              if (head_r == LW'(1)) begin
                cend_r <= 1'b1;
                if (lfill_r == '0) begin
                  idle_r <= 1'b1;
                  st_r <= S_OUT;
                end else st_r <= S_LOAD;
              end else st_r <= S_OUT;
            end
          end else if (c_r.is_drop) begin
            if (c_r.drop_count == '0) st_r <= S_OUT;
            else if ((RFW+9)'(count) < (RFW+9)'(c_r.drop_count)) begin
              stat_r <= cbf_pkg::ST_EMPTY;
              st_r <= S_OUT;
            end else begin
              total_r <= (LW+9)'(head_r);
              left_r  <= c_r.drop_count - 8'd1;
              st_r    <= S_WALK;
            end
          end else if (c_r.is_clear) begin
            st_r <= S_OUT;
            brd_r <= '0; bwr_r <= '0; bfill_r <= '0;
            lrd_r <= '0; lwr_r <= '0; lfill_r <= '0;
            head_r <= '0; tail_r <= '0; idle_r <= 1'b1;
          end else begin
            // unused kinds leave the state alone
            st_r <= S_OUT;
          end
        end
        S_WALK: begin
          // lq_r holds record at lrd_r (registered read)
          if (left_r == '0) st_r <= S_FIN;
          else if (lfill_r == '0) left_r <= '0;
          else begin
            st_r <= S_FIN; // S_FIN adds the record length once the registered read of the next record settles
            ldhead_r <= 1'b1;
          end
        end
        S_FIN: begin
          if (ldhead_r) begin
            total_r <= total_r + (LW+9)'(lq_r);
            lrd_r <= linc(lrd_r); lfill_r <= lfill_r - 1'b1;
            left_r <= left_r - 8'd1; ldhead_r <= 1'b0;
            st_r <= S_WALK;
          end else begin
            // psum stays below twice the depth: one compare and subtract wraps it
            brd_r   <= (psum >= (DAW+LW+10)'(DATA_DEPTH)) ?
                       DAW'(psum - (DAW+LW+10)'(DATA_DEPTH)) : DAW'(psum);
            bfill_r <= bfill_r - DFW'(tclip);
            head_r  <= '0;
            if (lfill_r == '0) begin
              idle_r <= 1'b1;
              st_r <= S_OUT;
            end else st_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          // lq_r valid: registered read of lmem[lrd_r] settled
          head_r <= lq_r; lrd_r <= linc(lrd_r);
          lfill_r <= lfill_r - 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!full_r || out_pop) begin
            full_r <= 1'b1;
            out_status <= stat_r;
            out_rd_byte <= ok_r ? rbyte_r : 8'd0;
            out_chapter_end <= cend_r;
            out_head_len <= 11'(head_r);
            out_chapter_count <= 7'(count);
            out_data_free <= 11'(DFW'(DATA_DEPTH) - bfill_r);
            out_record_free <= 7'(RFW'(REC_DEPTH) - lfill_r);
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_fill_rng: assert property (@(posedge clk) disable iff (!rst_n)
    bfill_r <= DFW'(DATA_DEPTH)) else $error("byte fill over depth");
  a_rec_rng: assert property (@(posedge clk) disable iff (!rst_n)
    lfill_r <= RFW'(REC_DEPTH)) else $error("record fill over depth");
  a_idle_head: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && idle_r) |-> head_r == '0) else $error("idle head nonzero");

endmodule

/* hw/rtl/chaptered_byte_fifo_core.sv */
// Chaptered byte FIFO: write, end, clear, plain and refused items pass S_IDLE, S_EXEC
// and S_OUT; a read that ends a chapter while records wait adds S_LOAD (next head fetched),
// and a delete of N chapters walks the length store through S_WALK and S_FIN for each
// further record, then a final S_WALK and S_FIN, plus S_LOAD when a next head is
// fetched. One item is in the back end at a time and a waiting result stalls it; a
// two-entry queue lets the front keep accepting meanwhile. Reset (rst_n low, synchronous)
// empties both stores logically and idles the head. Depends on cbf_pkg, cbf_front, cbf_back.
module chaptered_byte_fifo_core #(
  parameter int DATA_DEPTH = 1024,
  parameter int REC_DEPTH  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_wr_byte,
  input  logic [7:0]  in_drop_count,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [7:0]  out_rd_byte,
  output logic        out_chapter_end,
  output logic [10:0] out_head_len,
  output logic [6:0]  out_chapter_count,
  output logic [10:0] out_data_free,
  output logic [6:0]  out_record_free
);

  // Command path between front decode and back execution.
  logic          cmd_valid, cmd_take;
  cbf_pkg::cmd_t cmd;

  cbf_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_kind, .in_wr_byte, .in_drop_count,
    .cmd_valid, .cmd, .cmd_take
  );

  // Back end owns both stores and the single result register.
  cbf_back #(.DATA_DEPTH(DATA_DEPTH), .REC_DEPTH(REC_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .out_empty, .out_pop, .out_status, .out_rd_byte, .out_chapter_end,
    .out_head_len, .out_chapter_count, .out_data_free, .out_record_free
  );

endmodule
